// ===== rtl/bsfd_pkg.sv =====
// Package for the byte-stuffed frame deframer: codes, types and defaults.
`default_nettype none
package bsfd_pkg;

  // Default depth of the request queue between front and back
  localparam int unsigned QueueDepthDef = 4;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_CODE  = 2'd0,
    CFG_END_CODE    = 2'd1,
    CFG_ESCAPE_CODE = 2'd2
  } cfg_idx_e;

  // Reset values of the configuration registers
  localparam logic [7:0] StartCodeRst  = 8'd2;
  localparam logic [7:0] EndCodeRst    = 8'd3;
  localparam logic [7:0] EscapeCodeRst = 8'd16;

  // Frame parsing phase
  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_DATA  = 3'd1,
    PH_ESC   = 3'd2,
    PH_DONE  = 3'd3,
    PH_ERROR = 3'd4
  } phase_e;

  // Result kind and status codes
  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;
  localparam logic StatusOk   = 1'b0;
  localparam logic StatusErr  = 1'b1;

  // One classified request: an optional data result, then an optional status result
  typedef struct packed {
    logic       has_data;
    logic [7:0] data;
    logic       has_status;
    logic       status;
    logic [7:0] count;
  } cmd_t;

  // Queue occupancy flags seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

// ===== rtl/bsfd_front.sv =====
// Front part: configuration registers, frame phase tracking and request classification.
`default_nettype none
module bsfd_front
  import bsfd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         frame_byte_i,
  input  wire logic               frame_last_i,
  input  wire qstat_t             qstat_i,
  output logic                    push_o,
  output cmd_t                    cmd_o
);

  logic [7:0] start_code_q, end_code_q, escape_code_q;
  phase_e     phase_q, phase_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] cnt_inc;
  logic       accept;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_code_q  <= StartCodeRst;
      end_code_q    <= EndCodeRst;
      escape_code_q <= EscapeCodeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_CODE:  start_code_q  <= cfg_data_i;
        CFG_END_CODE:    end_code_q    <= cfg_data_i;
        CFG_ESCAPE_CODE: escape_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold phase and payload count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      cnt_q   <= 8'd0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  assign accept     = in_valid_i && !qstat_i.full;
  assign in_stall_o = qstat_i.full;
  assign cnt_inc    = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;

  // Classify the byte, advance phase and build the request
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    if (accept) begin
      case (phase_q)
        PH_START: begin
          cnt_d = 8'd0;
          if (frame_byte_i == start_code_q) begin
            if (frame_last_i) begin
              cmd_o.has_status = 1'b1;
              cmd_o.status     = StatusErr;
              phase_d          = PH_START;
            end else begin
              phase_d = PH_DATA;
            end
          end else begin
            cmd_o.has_status = 1'b1;
            cmd_o.status     = StatusErr;
            phase_d          = frame_last_i ? PH_START : PH_ERROR;
          end
        end
        PH_DATA: begin
          if (frame_byte_i == escape_code_q) begin
            if (frame_last_i) begin
              cmd_o.has_status = 1'b1;
              cmd_o.status     = StatusErr;
              cmd_o.count      = cnt_q;
              phase_d          = PH_START;
            end else begin
              phase_d = PH_ESC;
            end
          end else if (frame_byte_i == end_code_q) begin
            cmd_o.has_status = 1'b1;
            cmd_o.status     = StatusOk;
            cmd_o.count      = cnt_q;
            phase_d          = frame_last_i ? PH_START : PH_DONE;
          end else begin
            cnt_d          = cnt_inc;
            cmd_o.has_data = 1'b1;
            cmd_o.data     = frame_byte_i;
            if (frame_last_i) begin
              cmd_o.has_status = 1'b1;
              cmd_o.status     = StatusErr;
              cmd_o.count      = cnt_inc;
              phase_d          = PH_START;
            end
          end
        end
        PH_ESC: begin
          cnt_d          = cnt_inc;
          cmd_o.has_data = 1'b1;
          cmd_o.data     = frame_byte_i;
          if (frame_last_i) begin
            cmd_o.has_status = 1'b1;
            cmd_o.status     = StatusErr;
            cmd_o.count      = cnt_inc;
            phase_d          = PH_START;
          end else begin
            phase_d = PH_DATA;
          end
        end
        default: begin
          // Skip trailing bytes up to the frame's last byte
          if (frame_last_i) phase_d = PH_START;
        end
      endcase
    end
  end

  // Queue only requests that cause results
  assign push_o = accept && (cmd_o.has_data || cmd_o.has_status);

endmodule
`default_nettype wire

// ===== rtl/bsfd_queue.sv =====
// Request queue: small register FIFO between front and back.
`default_nettype none
module bsfd_queue
  import bsfd_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output cmd_t      head_o,
  output qstat_t    qstat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  // Store pushed requests
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head_o        = mem_q[rd_ptr_q];
  assign qstat_o.full  = (cnt_q == CntFull);
  assign qstat_o.empty = (cnt_q == '0);

endmodule
`default_nettype wire

// ===== rtl/bsfd_back.sv =====
// Back part: expands queued requests into result items through an output register.
`default_nettype none
module bsfd_back
  import bsfd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cmd_t   head_i,
  input  wire qstat_t qstat_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire logic   out_stall_i,
  output logic        kind_o,
  output logic [7:0]  data_byte_o,
  output logic        status_o,
  output logic [7:0]  data_count_o,
  output logic        last_o
);

  logic       valid_q, valid_d;
  logic       sub_q, sub_d;
  logic       kind_q, kind_d;
  logic [7:0] data_q, data_d;
  logic       status_q, status_d;
  logic [7:0] count_q, count_d;
  logic       last_q, last_d;
  logic       load;

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sub_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sub_q   <= sub_d;
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    data_q   <= data_d;
    status_q <= status_d;
    count_q  <= count_d;
    last_q   <= last_d;
  end

  assign load = !valid_q || !out_stall_i;

  // Pick the next result: data part first, then status part
  always_comb begin
    valid_d  = valid_q;
    sub_d    = sub_q;
    kind_d   = kind_q;
    data_d   = data_q;
    status_d = status_q;
    count_d  = count_q;
    last_d   = last_q;
    pop_o    = 1'b0;
    if (load) begin
      valid_d = !qstat_i.empty;
      if (!qstat_i.empty) begin
        if (head_i.has_data && !sub_q) begin
          kind_d   = KindData;
          data_d   = head_i.data;
          status_d = StatusOk;
          count_d  = 8'd0;
          last_d   = !head_i.has_status;
          sub_d    = head_i.has_status;
          pop_o    = !head_i.has_status;
        end else begin
          kind_d   = KindStatus;
          data_d   = 8'd0;
          status_d = head_i.status;
          count_d  = head_i.count;
          last_d   = 1'b1;
          sub_d    = 1'b0;
          pop_o    = 1'b1;
        end
      end
    end
  end

  assign out_valid_o  = valid_q;
  assign kind_o       = kind_q;
  assign data_byte_o  = data_q;
  assign status_o     = status_q;
  assign data_count_o = count_q;
  assign last_o       = last_q;

endmodule
`default_nettype wire

// ===== rtl/byte_stuffed_frame_deframer_top.sv =====
// Top level of the byte-stuffed frame deframer: front, request queue and back.
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i / in_stall_o frame_byte_i, frame_last_i
//  out      output     out_valid_o/out_stall_i kind_o, data_byte_o, status_o,
//                                              data_count_o, last_o
//  cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// One byte is accepted per cycle while the request queue has room; the
// front decides phase and count in the cycle of acceptance.
// A byte causing two results (data, then error status) loads the output
// register once per result; otherwise one result per cycle while out_stall_i
// is low. The output register is loaded from the queue head.
// Reset clears phase, count, queue and output valid; registers go to 2, 3, 16.
// An output stall fills the queue (QueueDepth requests) before input stalls.
`default_nettype none
module byte_stuffed_frame_deframer_top
  import bsfd_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         frame_byte_i,
  input  wire logic               frame_last_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    kind_o,
  output logic [7:0]              data_byte_o,
  output logic                    status_o,
  output logic [7:0]              data_count_o,
  output logic                    last_o
);

  qstat_t qstat;
  logic   push, pop;
  cmd_t   cmd, head;

  bsfd_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .frame_byte_i,
    .frame_last_i,
    .qstat_i (qstat),
    .push_o  (push),
    .cmd_o   (cmd)
  );

  bsfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  bsfd_back u_back (
    .clk_i,
    .rst_ni,
    .head_i  (head),
    .qstat_i (qstat),
    .pop_o   (pop),
    .out_valid_o,
    .out_stall_i,
    .kind_o,
    .data_byte_o,
    .status_o,
    .data_count_o,
    .last_o
  );

  // Never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !qstat.full)
    else $error("request pushed into full queue");

  // Never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !qstat.empty)
    else $error("request popped from empty queue");

  // A status result always closes its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && (kind_o == KindStatus)) |-> last_o)
    else $error("status result without last");

  // A data result that is not last is followed by its status result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && !out_stall_i && (kind_o == KindData) && !last_o)
      |=> (out_valid_o && (kind_o == KindStatus)))
    else $error("data result not followed by status");

endmodule
`default_nettype wire

// ===== dv/bsfd_result_checker.sv =====
// Result checker for the byte-stuffed frame deframer: tracks requests, predicts and compares.
module bsfd_result_checker
  import bsfd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [7:0]         frame_byte_i,
  input  logic               frame_last_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               kind_i,
  input  logic [7:0]         data_byte_i,
  input  logic               status_i,
  input  logic [7:0]         data_count_i,
  input  logic               last_i,
  output int                 pending_o,
  output int                 errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       status;
    logic [7:0] data_count;
    logic       last;
  } result_t;

  result_t    expected_q[$];
  phase_e     phase         = PH_START;
  logic [7:0] payload_count = '0;
  logic [7:0] start_code    = StartCodeRst;
  logic [7:0] end_code      = EndCodeRst;
  logic [7:0] escape_code   = EscapeCodeRst;
  int         errors        = 0;

  function automatic result_t status_result(input logic st, input logic [7:0] cnt);
    result_t r;
    r.kind       = KindStatus;
    r.data_byte  = '0;
    r.status     = st;
    r.data_count = cnt;
    r.last       = 1'b1;
    return r;
  endfunction

  // Emit a payload byte; a frame that stops on it also gets an error status
  task automatic accept_data(input logic [7:0] b, input logic lst);
    result_t r;
    if (payload_count != 8'hFF) payload_count++;
    r.kind       = KindData;
    r.data_byte  = b;
    r.status     = StatusOk;
    r.data_count = '0;
    r.last       = !lst;
    expected_q.push_back(r);
    if (lst) begin
      expected_q.push_back(status_result(StatusErr, payload_count));
      phase = PH_START;
    end else begin
      phase = PH_DATA;
    end
  endtask

  // Advance the deframing state by one received byte
  task automatic deframe_byte(input logic [7:0] b, input logic lst);
    case (phase)
      PH_START: begin
        payload_count = '0;
        if (b == start_code && !lst) begin
          phase = PH_DATA;
        end else begin
          expected_q.push_back(status_result(StatusErr, '0));
          phase = lst ? PH_START : PH_ERROR;
        end
      end
      PH_DATA: begin
        if (b == escape_code) begin
          if (lst) begin
            expected_q.push_back(status_result(StatusErr, payload_count));
            phase = PH_START;
          end else begin
            phase = PH_ESC;
          end
        end else if (b == end_code) begin
          expected_q.push_back(status_result(StatusOk, payload_count));
          phase = lst ? PH_START : PH_DONE;
        end else begin
          accept_data(b, lst);
        end
      end
      PH_ESC: accept_data(b, lst);
      default: begin
        if (lst) phase = PH_START;
      end
    endcase
  endtask

  // Compare one delivered result with the oldest prediction
  task automatic check_result(input result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected result: kind %0d data_byte %0h status %0d data_count %0d last %0d",
             got.kind, got.data_byte, got.status, got.data_count, got.last);
      errors++;
    end else begin
      want = expected_q.pop_front();
      if (got.kind != want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.data_byte != want.data_byte) begin
        $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
        errors++;
      end
      if (got.status != want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.data_count != want.data_count) begin
        $error("data_count: expected %0d, got %0d", want.data_count, got.data_count);
        errors++;
      end
      if (got.last != want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    end
  endtask

  // Watch the channels: check results, track code writes, predict from requests
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    if (!rst_ni) begin
      phase         = PH_START;
      payload_count = '0;
      start_code    = StartCodeRst;
      end_code      = EndCodeRst;
      escape_code   = EscapeCodeRst;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.kind       = kind_i;
        got.data_byte  = data_byte_i;
        got.status     = status_i;
        got.data_count = data_count_i;
        got.last       = last_i;
        check_result(got);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START_CODE:  start_code  = cfg_data_i;
          CFG_END_CODE:    end_code    = cfg_data_i;
          CFG_ESCAPE_CODE: escape_code = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) deframe_byte(frame_byte_i, frame_last_i);
      pending_o <= expected_q.size();
    end
    errors_o <= errors;
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the deframer testbench: clock, reset, code writes, frame stimulus and verdict.
module testbench import bsfd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned       SettleCycles  = 16;
  localparam int unsigned       HoldOffCycles = 80;
  localparam int unsigned       TimeoutNs     = 2_000_000;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  typedef enum {
    SHAPE_GOOD,
    SHAPE_BAD_START,
    SHAPE_CUT_DATA,
    SHAPE_CUT_ESC,
    SHAPE_CUT_START,
    SHAPE_NOISE
  } frame_shape_e;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i    = '0;
  logic [7:0]         cfg_data_i   = '0;
  logic               in_valid_i   = 1'b0;
  logic [7:0]         frame_byte_i = '0;
  logic               frame_last_i = 1'b0;
  logic               out_stall_i  = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic               kind_o;
  logic [7:0]         data_byte_o;
  logic               status_o;
  logic [7:0]         data_count_o;
  logic               last_o;

  int pending_results;
  int checker_errors;

  // Stimulus state: codes in force, frame under construction, sender bursts
  logic [7:0] cur_start = StartCodeRst;
  logic [7:0] cur_end   = EndCodeRst;
  logic [7:0] cur_esc   = EscapeCodeRst;
  logic [7:0] frame_bytes[$];
  int         burst_left = 0;
  int         sent_bytes = 0;

  // Receiver stall state
  int          hold_req   = 0;
  int          hold_seen  = 0;
  int          hold_left  = 0;
  int          stall_mode = 0;
  logic [31:0] stall_cyc  = '0;

  always #5 clk_i = ~clk_i;

  byte_stuffed_frame_deframer_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .frame_byte_i (frame_byte_i),
    .frame_last_i (frame_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .data_byte_o  (data_byte_o),
    .status_o     (status_o),
    .data_count_o (data_count_o),
    .last_o       (last_o)
  );

  bsfd_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .frame_byte_i (frame_byte_i),
    .frame_last_i (frame_last_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_i       (kind_o),
    .data_byte_i  (data_byte_o),
    .status_i     (status_o),
    .data_count_i (data_count_o),
    .last_i       (last_o),
    .pending_o    (pending_results),
    .errors_o     (checker_errors)
  );

  // Stall the output: a long hold-off on request, else a pattern that changes mode
  always @(posedge clk_i) begin
    stall_cyc <= stall_cyc + 1;
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HoldOffCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (stall_cyc[6:0] == '0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= stall_cyc[2];
      endcase
    end
  end

  // Offer one request, opening a random gap at the end of each burst
  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    frame_byte_i <= b;
    frame_last_i <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_bytes++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
    frame_bytes.delete();
  endtask

  // Drop valid, drain every expected result, then let skipped bytes settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all three codes back to back, after a write to the unused index
  task automatic set_codes(input logic [7:0] s, input logic [7:0] e, input logic [7:0] x);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgIdxUnused;
    cfg_data_i <= 8'($urandom);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_START_CODE;
    cfg_data_i <= s;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_END_CODE;
    cfg_data_i <= e;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ESCAPE_CODE;
    cfg_data_i <= x;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_start = s;
    cur_end   = e;
    cur_esc   = x;
  endtask

  // Payload byte biased toward the codes in force
  function automatic logic [7:0] rand_payload();
    case ($urandom_range(0, 7))
      0:       return cur_start;
      1:       return cur_end;
      2:       return cur_esc;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Append payload, escaping escape and end code bytes and now and then a plain one
  task automatic add_payload(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = rand_payload();
      if (b == cur_esc || b == cur_end || $urandom_range(0, 9) == 0) frame_bytes.push_back(cur_esc);
      frame_bytes.push_back(b);
    end
  endtask

  task automatic build_good(input int n);
    frame_bytes.push_back(cur_start);
    add_payload(n);
    frame_bytes.push_back(cur_end);
    repeat ($urandom_range(0, 3)) frame_bytes.push_back(rand_payload());
  endtask

  task automatic build_frame(input frame_shape_e shape);
    logic [7:0] b;
    case (shape)
      SHAPE_GOOD: begin
        build_good(($urandom_range(0, 15) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 10));
      end
      SHAPE_BAD_START: begin
        do b = 8'($urandom_range(0, 255)); while (b == cur_start);
        frame_bytes.push_back(b);
        repeat ($urandom_range(0, 4)) frame_bytes.push_back(rand_payload());
      end
      SHAPE_CUT_DATA: begin
        frame_bytes.push_back(cur_start);
        add_payload($urandom_range(0, 6));
        do b = 8'($urandom_range(0, 255)); while (b == cur_esc || b == cur_end);
        frame_bytes.push_back(b);
      end
      SHAPE_CUT_ESC: begin
        frame_bytes.push_back(cur_start);
        add_payload($urandom_range(0, 6));
        frame_bytes.push_back(cur_esc);
      end
      SHAPE_CUT_START: frame_bytes.push_back(cur_start);
      default: begin
        repeat ($urandom_range(1, 6)) frame_bytes.push_back(rand_payload());
      end
    endcase
  endtask

  // Send random frames, mostly well formed, until about n more requests went in
  task automatic run_frames(input int n);
    int goal;
    int r;
    goal = sent_bytes + n;
    while (sent_bytes < goal) begin
      r = $urandom_range(0, 99);
      if (r < 70)      build_frame(SHAPE_GOOD);
      else if (r < 76) build_frame(SHAPE_BAD_START);
      else if (r < 82) build_frame(SHAPE_CUT_DATA);
      else if (r < 88) build_frame(SHAPE_CUT_ESC);
      else if (r < 92) build_frame(SHAPE_CUT_START);
      else             build_frame(SHAPE_NOISE);
      send_frame();
    end
  endtask

  initial begin
    #(TimeoutNs);
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [7:0] s;
    logic [7:0] e;
    logic [7:0] x;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames at the reset codes
    frame_bytes = '{StartCodeRst, 8'h00, 8'hFF, EscapeCodeRst, EndCodeRst, EndCodeRst};
    send_frame();
    frame_bytes = '{StartCodeRst};
    send_frame();
    frame_bytes = '{8'h55, StartCodeRst, EndCodeRst};
    send_frame();
    frame_bytes = '{8'hFF};
    send_frame();
    frame_bytes = '{StartCodeRst, 8'h41, EscapeCodeRst};
    send_frame();
    frame_bytes = '{StartCodeRst, 8'h7E};
    send_frame();
    frame_bytes = '{StartCodeRst, EndCodeRst, StartCodeRst, EscapeCodeRst, 8'hAA};
    send_frame();
    frame_bytes = '{StartCodeRst, 8'h80, EndCodeRst};
    send_frame();

    // Random frames; hold the output off while the sender keeps pushing
    run_frames(100);
    hold_req   <= hold_req + 1;
    burst_left = 150;
    run_frames(200);

    // Extreme codes, with one frame long enough to saturate the count
    wait_idle();
    set_codes(8'h00, 8'hFF, 8'h80);
    build_good(270);
    send_frame();
    run_frames(40);

    wait_idle();
    set_codes(8'hFF, 8'h00, 8'h01);
    run_frames(250);

    // All codes equal: escape wins over end inside a frame
    wait_idle();
    set_codes(8'h5A, 8'h5A, 8'h5A);
    run_frames(150);

    // Distinct random codes, then fully random ones
    wait_idle();
    s = 8'($urandom);
    do e = 8'($urandom); while (e == s);
    do x = 8'($urandom); while (x == s || x == e);
    set_codes(s, e, x);
    run_frames(250);

    wait_idle();
    set_codes(8'($urandom), 8'($urandom), 8'($urandom));
    run_frames(250);

    wait_idle();
    if (checker_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bsfd_pkg.sv
rtl/bsfd_front.sv
rtl/bsfd_queue.sv
rtl/bsfd_back.sv
rtl/byte_stuffed_frame_deframer_top.sv
dv/bsfd_result_checker.sv
dv/testbench.sv
